// ===== hdl/gpc_pkg.sv =====
// Shared types and constants for the GPIO pin configuration controller.
package gpc_pkg;

  // Number of pins held in the configuration table and its address width.
  localparam int PIN_COUNT = 58;
  localparam int PIN_AW    = $clog2(PIN_COUNT);

  // Field widths of a command and of a result.
  localparam int OP_W   = 3;
  localparam int PIN_W  = 6;
  localparam int FUNC_W = 3;
  localparam int PULL_W = 2;
  localparam int STAT_W = 2;

  // Command codes; the remaining codes are unknown commands.
  typedef enum logic [OP_W-1:0] {
    OP_SET_CONFIG = 3'd0,
    OP_GET_CONFIG = 3'd1,
    OP_WRITE      = 3'd2,
    OP_TOGGLE     = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_INVAL      = 2'd1,
    ST_NOT_OUTPUT = 2'd2,
    ST_UNKNOWN    = 2'd3
  } status_t;

  // Function and pull codes with a special meaning.
  localparam logic [FUNC_W-1:0] FUNC_OUTPUT  = 3'd1;
  localparam logic [PULL_W-1:0] PULL_INVALID = 2'd3;

  // One entry of the pin table.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PULL_W-1:0] pull;
    logic              latch;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the command in and look up the pin entry
    logic commit;   // execute, update the table and load the result
  } cmd_t;

endpackage

// ===== hdl/gpc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module gpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/gpc_ctrl.sv =====
// Controller state machine that sequences one command at a time.
module gpc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output gpc_pkg::cmd_t cmd
);

  import gpc_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register can be loaded when it is empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;

  // Commands to the datapath.
  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.commit  = (state_r == S_EXEC) && slot_free;
  end

  // Next state and result valid.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/gpc_datapath.sv =====
// Datapath: command registers, pin table, command execution and result register.
module gpc_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gpc_pkg::cmd_t                cmd,
  input  logic [gpc_pkg::OP_W-1:0]     in_opcode,
  input  logic [gpc_pkg::PIN_W-1:0]    in_pin,
  input  logic [gpc_pkg::FUNC_W-1:0]   in_function_code,
  input  logic [gpc_pkg::PULL_W-1:0]   in_pull_mode,
  input  logic                         in_drive_value,
  input  logic                         in_external_level,
  output logic [gpc_pkg::STAT_W-1:0]   out_status,
  output logic [gpc_pkg::PIN_W-1:0]    out_result_pin,
  output logic [gpc_pkg::FUNC_W-1:0]   out_result_function,
  output logic [gpc_pkg::PULL_W-1:0]   out_result_pull,
  output logic                         out_result_level
);

  import gpc_pkg::*;

  // Captured command.
  logic [OP_W-1:0]   op_r;
  logic [PIN_W-1:0]  pin_r;
  logic [FUNC_W-1:0] func_r;
  logic [PULL_W-1:0] pull_r;
  logic              drive_r;
  logic              ext_r;

  // Result register.
  logic [STAT_W-1:0] status_r;
  logic [PIN_W-1:0]  res_pin_r;
  logic [FUNC_W-1:0] res_func_r;
  logic [PULL_W-1:0] res_pull_r;
  logic              res_level_r;

  // One bit per pin: set once the table entry has been written since reset.
  logic [PIN_COUNT-1:0] written_r;

  logic              pin_ok;
  logic [PIN_AW-1:0] addr;
  entry_t            rd_entry;
  entry_t            cur;
  entry_t            wr_entry;
  logic              wr_en;
  logic              level;
  status_t           status_nxt;
  logic [PIN_W-1:0]  res_pin_nxt;
  logic [FUNC_W-1:0] res_func_nxt;
  logic [PULL_W-1:0] res_pull_nxt;
  logic              res_level_nxt;

  // Command capture on a transfer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_opcode;
      pin_r   <= in_pin;
      func_r  <= in_function_code;
      pull_r  <= in_pull_mode;
      drive_r <= in_drive_value;
      ext_r   <= in_external_level;
    end
  end

  // Pin table; the lookup is issued with the transfer and returns in the execute cycle.
  gpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PIN_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_entry),
    .rd_en   (cmd.capture),
    .rd_addr (in_pin[PIN_AW-1:0]),
    .rd_data (rd_entry)
  );

  assign addr   = pin_r[PIN_AW-1:0];
  assign pin_ok = ({{(32-PIN_W){1'b0}}, pin_r} < PIN_COUNT);

  // An entry never written since reset reads as input, no pull, latch low.
  always_comb begin
    cur = '0;
    if (pin_ok && written_r[addr]) begin
      cur = rd_entry;
    end
  end

  assign level = (cur.func == FUNC_OUTPUT) ? cur.latch : ext_r;

  // Command execution.
  always_comb begin
    status_nxt    = ST_OK;
    res_pin_nxt   = '0;
    res_func_nxt  = '0;
    res_pull_nxt  = '0;
    res_level_nxt = 1'b0;
    wr_entry      = cur;
    wr_en         = 1'b0;
    case (op_r)
      OP_SET_CONFIG: begin
        if (!pin_ok || pull_r == PULL_INVALID) begin
          status_nxt = ST_INVAL;
        end else begin
          wr_entry.pull = pull_r;
          wr_entry.func = func_r;
          if (func_r == FUNC_OUTPUT) begin
            wr_entry.latch = drive_r;
          end
          wr_en = cmd.commit;
        end
      end
      OP_GET_CONFIG: begin
        if (!pin_ok) begin
          status_nxt = ST_INVAL;
        end else begin
          res_pin_nxt   = pin_r;
          res_func_nxt  = cur.func;
          res_pull_nxt  = cur.pull;
          res_level_nxt = level;
        end
      end
      OP_WRITE, OP_TOGGLE: begin
        if (!pin_ok) begin
          status_nxt = ST_INVAL;
        end else if (cur.func != FUNC_OUTPUT) begin
          status_nxt = ST_NOT_OUTPUT;
        end else begin
          wr_entry.latch = (op_r == OP_WRITE) ? drive_r : !cur.latch;
          wr_en          = cmd.commit;
        end
      end
      OP_READ: begin
        if (!pin_ok) begin
          status_nxt = ST_INVAL;
        end else begin
          res_pin_nxt   = pin_r;
          res_level_nxt = level;
        end
      end
      default: begin
        status_nxt = ST_UNKNOWN;
      end
    endcase
  end

  // Written-entry flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr_en) begin
      written_r[addr] <= 1'b1;
    end
  end

  // Result register, loaded when the command commits.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r    <= status_nxt;
      res_pin_r   <= res_pin_nxt;
      res_func_r  <= res_func_nxt;
      res_pull_r  <= res_pull_nxt;
      res_level_r <= res_level_nxt;
    end
  end

  assign out_status          = status_r;
  assign out_result_pin      = res_pin_r;
  assign out_result_function = res_func_r;
  assign out_result_pull     = res_pull_r;
  assign out_result_level    = res_level_r;

endmodule

// ===== hdl/gpio_pin_config_controller.sv =====
// Top level of the GPIO pin configuration controller.
//
// The block executes one pin command at a time and gives one result for each. A command
// has a transfer cycle, in which the pin's entry is looked up in the table memory
// (registered read), and an execute cycle, in which the entry is updated and the result
// register loaded. A new command can be transferred in the cycle after execution even
// while the previous result still waits; a stalled result that is still held when the
// next command executes keeps that command in its execute step until it has been taken.
// The table needs no clearing pass: a flag per pin, cleared by reset, makes unwritten
// entries read as input, no pull and latch low.
module gpio_pin_config_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gpc_pkg::OP_W-1:0]     in_opcode,
  input  logic [gpc_pkg::PIN_W-1:0]    in_pin,
  input  logic [gpc_pkg::FUNC_W-1:0]   in_function_code,
  input  logic [gpc_pkg::PULL_W-1:0]   in_pull_mode,
  input  logic                         in_drive_value,
  input  logic                         in_external_level,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gpc_pkg::STAT_W-1:0]   out_status,
  output logic [gpc_pkg::PIN_W-1:0]    out_result_pin,
  output logic [gpc_pkg::FUNC_W-1:0]   out_result_function,
  output logic [gpc_pkg::PULL_W-1:0]   out_result_pull,
  output logic                         out_result_level
);

  import gpc_pkg::*;

  cmd_t cmd;

  // Sequencing.
  gpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Table and execution.
  gpc_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_opcode           (in_opcode),
    .in_pin              (in_pin),
    .in_function_code    (in_function_code),
    .in_pull_mode        (in_pull_mode),
    .in_drive_value      (in_drive_value),
    .in_external_level   (in_external_level),
    .out_status          (out_status),
    .out_result_pin      (out_result_pin),
    .out_result_function (out_result_function),
    .out_result_pull     (out_result_pull),
    .out_result_level    (out_result_level)
  );

`ifndef SYNTHESIS
  // A transferred command is being executed in the next cycle, so the input is stalled.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled while a command executes");

  // A new result only appears when a command was being executed.
  a_result_from_command: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a command");

  // A failed command carries nothing but its status.
  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_result_pin == '0 && out_result_function == '0 &&
       out_result_pull == '0 && !out_result_level))
    else $error("failed command with non-zero result fields");
`endif

endmodule
